>>> rtl/cvmr_pkg.sv
// ----------------------------------------------------------------------------
// cvmr_pkg
// Shared types, widths and register codes of the view matrix recenter unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cvmr_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Translation datapath widths.
  localparam int ACC_W  = 2 * WORD_BITS + 2;    // t * 2^F - sum R * rc
  localparam int PROD_W = ACC_W + WORD_BITS;    // scaled accumulator
  localparam int Q_W    = PROD_W - 2 * FRAC_BITS;

  localparam int ROWS = 3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [Q_W-1:0]       qword_t;

  typedef enum logic [1:0] {
    REG_RECENTER_X = 2'd0,
    REG_RECENTER_Y = 2'd1,
    REG_RECENTER_Z = 2'd2,
    REG_SCENE_SCALE = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    word_t c0;
    word_t c1;
    word_t c2;
    word_t c3;
  } row_t;

endpackage

`default_nettype wire

>>> rtl/cvmr_det_zero.sv
// ----------------------------------------------------------------------------
// cvmr_det_zero
// Six-stage pipeline that computes det(R) exactly and flags a zero result.
// ----------------------------------------------------------------------------
`default_nettype none

module cvmr_det_zero import cvmr_pkg::*; (
  input  logic  clk_i,
  input  word_t rot_i [9],
  output logic  zero_o
);

  localparam int PW = 2 * WORD_BITS;
  localparam int LW = 2 * WORD_BITS + 1;
  localparam int TW = 3 * WORD_BITS;
  localparam int DW = TW + 1;
  localparam int SW = TW + 3;

  // Factor indexes of the six terms; even terms add, odd terms subtract.
  localparam int IA [6] = '{0, 0, 1, 1, 2, 2};
  localparam int IB [6] = '{4, 5, 5, 3, 3, 4};
  localparam int IC [6] = '{8, 7, 6, 8, 7, 6};

  logic signed [PW-1:0] ab_q   [6];
  word_t                c1_q   [6];
  logic signed [LW-1:0] lo_q   [6];
  logic signed [PW-1:0] hi_q   [6];
  logic signed [TW-1:0] term_q [6];
  logic signed [DW-1:0] pair_q [3];
  logic signed [SW-1:0] sum_q;
  logic                 zero_q;

  always_ff @(posedge clk_i) begin
    for (int n = 0; n < 6; n++) begin
      ab_q[n]   <= PW'(rot_i[IA[n]]) * PW'(rot_i[IB[n]]);
      c1_q[n]   <= rot_i[IC[n]];
      // The 64-bit product is split so each multiply stays 33 x 32.
      lo_q[n]   <= $signed({1'b0, ab_q[n][WORD_BITS-1:0]}) * LW'(c1_q[n]);
      hi_q[n]   <= PW'($signed(ab_q[n][PW-1:WORD_BITS])) * PW'(c1_q[n]);
      term_q[n] <= (TW'(hi_q[n]) <<< WORD_BITS) + TW'(lo_q[n]);
    end
    for (int m = 0; m < 3; m++) begin
      pair_q[m] <= DW'(term_q[2*m]) - DW'(term_q[2*m+1]);
    end
    sum_q  <= SW'(pair_q[0]) + SW'(pair_q[1]) + SW'(pair_q[2]);
    zero_q <= (sum_q == '0);
  end

  assign zero_o = zero_q;

endmodule

`default_nettype wire

>>> rtl/cvmr_xlate.sv
// ----------------------------------------------------------------------------
// cvmr_xlate
// Six-stage pipeline for one output row: carries the row of A and computes
// scale * (t * 2^F - sum R * rc) / 2^(2F), truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cvmr_xlate import cvmr_pkg::*; (
  input  logic   clk_i,
  input  word_t  col_i [3],
  input  word_t  t_i,
  input  word_t  rc_i  [3],
  input  word_t  scale_i,
  output word_t  col_o [3],
  output qword_t q_o
);

  localparam int PW = 2 * WORD_BITS;
  localparam int SW = 2 * WORD_BITS + 1;
  localparam int LW = 2 * WORD_BITS + 1;

  word_t                   cd_q [6][3];
  logic signed [PW-1:0]    p_q  [3];
  word_t                   t_q;
  logic signed [SW-1:0]    s_q;
  logic signed [SW-1:0]    d_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [LW-1:0]    mlo_q;
  logic signed [ACC_W-1:0] mhi_q;
  logic signed [PROD_W-1:0] prod_q;
  qword_t                  q_q;
  logic signed [PROD_W-1:0] rnd_d;
  logic signed [PROD_W-1:0] biased_d;

  always_comb begin
    rnd_d = '0;
    // Negative values are biased so the shift truncates toward zero.
    if (prod_q[PROD_W-1]) begin
      rnd_d[2*FRAC_BITS-1:0] = '1;
    end
    biased_d = prod_q + rnd_d;
  end

  always_ff @(posedge clk_i) begin
    cd_q[0] <= col_i;
    for (int s = 1; s < 6; s++) begin
      cd_q[s] <= cd_q[s-1];
    end
    for (int i = 0; i < 3; i++) begin
      p_q[i] <= PW'(col_i[i]) * PW'(rc_i[i]);
    end
    t_q    <= t_i;
    s_q    <= SW'(p_q[0]) + SW'(p_q[1]);
    d_q    <= (SW'(t_q) <<< FRAC_BITS) - SW'(p_q[2]);
    acc_q  <= ACC_W'(d_q) - ACC_W'(s_q);
    mlo_q  <= $signed({1'b0, acc_q[WORD_BITS-1:0]}) * LW'(scale_i);
    mhi_q  <= ACC_W'($signed(acc_q[ACC_W-1:WORD_BITS])) * ACC_W'(scale_i);
    prod_q <= (PROD_W'(mhi_q) <<< WORD_BITS) + PROD_W'(mlo_q);
    q_q    <= biased_d[PROD_W-1:2*FRAC_BITS];
  end

  assign col_o = cd_q[5];
  assign q_o   = q_q;

endmodule

`default_nettype wire

>>> rtl/camera_view_matrix_recenter_unit.sv
// ----------------------------------------------------------------------------
// camera_view_matrix_recenter_unit
// Builds the inverted view matrix [A | -A c'] with a recentered, scaled camera.
// ----------------------------------------------------------------------------
// Usage:
//   A word (R and t) is taken at a clock edge where start is high and busy is
//   low. Three row words follow, one per cycle, each marked by done_o; the
//   third carries last_o. The receiver cannot hold them off.
//   Each word passes through the row pipelines and the det(R) check and is
//   loaded into the row holding registers, which then drive rows 0, 1 and 2
//   in order. The datapath is a seven-stage pipeline, so a new word can be
//   accepted while earlier words are still in flight; busy rises after each
//   accepted word and holds off start so that the row words of one word do
//   not overlap those of the word before it.
//   Configuration: cfg_valid_i / cfg_ready_o carry a register index and data;
//   ready is always high. Write registers only while no word is in flight.
//   Reset clears all control state and sets the recenter offsets to 0 and the
//   scale to 1.0; the block can accept a word as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_view_matrix_recenter_unit import cvmr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  word_t      cfg_data_i,
  input  word_t      rot_00_i,
  input  word_t      rot_01_i,
  input  word_t      rot_02_i,
  input  word_t      rot_10_i,
  input  word_t      rot_11_i,
  input  word_t      rot_12_i,
  input  word_t      rot_20_i,
  input  word_t      rot_21_i,
  input  word_t      rot_22_i,
  input  word_t      view_tx_i,
  input  word_t      view_ty_i,
  input  word_t      view_tz_i,
  output logic       done_o,
  output logic [1:0] row_index_o,
  output word_t      col0_o,
  output word_t      col1_o,
  output word_t      col2_o,
  output word_t      col3_o,
  output logic       last_o,
  output logic       singular_o
);

  localparam word_t ONE    = word_t'(1 << FRAC_BITS);
  localparam word_t SAT_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t SAT_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  word_t      rc_q [3];
  word_t      scale_q;
  logic [1:0] gap_q, gap_d;
  logic [5:0] vld_q;
  logic       accept;
  logic       det_zero;
  word_t      rot [9];
  word_t      tv  [3];
  word_t      xcol [3][3];
  qword_t     xq   [3];
  row_t       hold_q [ROWS];
  row_t       row_d  [ROWS];
  logic       sing_q;
  logic       act_q;
  logic [1:0] row_q;
  row_t       out_row;

  assign accept      = start & ~busy;
  assign busy        = (gap_q != '0);
  assign cfg_ready_o = 1'b1;
  assign gap_d       = accept ? 2'd2 : (busy ? gap_q - 2'd1 : gap_q);

  assign rot = '{rot_00_i, rot_01_i, rot_02_i, rot_10_i, rot_11_i, rot_12_i,
                 rot_20_i, rot_21_i, rot_22_i};
  assign tv  = '{view_tx_i, view_ty_i, view_tz_i};

  cvmr_det_zero u_det (
    .clk_i  (clk_i),
    .rot_i  (rot),
    .zero_o (det_zero)
  );

  for (genvar k = 0; k < ROWS; k++) begin : g_row
    word_t cin [3];
    assign cin = '{rot[k], rot[3+k], rot[6+k]};

    cvmr_xlate u_xlate (
      .clk_i   (clk_i),
      .col_i   (cin),
      .t_i     (tv[k]),
      .rc_i    (rc_q),
      .scale_i (scale_q),
      .col_o   (xcol[k]),
      .q_o     (xq[k])
    );

    // Saturate the truncated translation to the word range.
    always_comb begin
      logic [Q_W-WORD_BITS:0] top;
      top = xq[k][Q_W-1:WORD_BITS-1];
      row_d[k].c0 = xcol[k][0];
      row_d[k].c1 = xcol[k][1];
      row_d[k].c2 = xcol[k][2];
      if ((&top) || (~|top)) begin
        row_d[k].c3 = xq[k][WORD_BITS-1:0];
      end else begin
        row_d[k].c3 = xq[k][Q_W-1] ? SAT_MIN : SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q    <= '{'0, '0, '0};
      scale_q <= ONE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_RECENTER_X:  rc_q[0] <= cfg_data_i;
        REG_RECENTER_Y:  rc_q[1] <= cfg_data_i;
        REG_RECENTER_Z:  rc_q[2] <= cfg_data_i;
        REG_SCENE_SCALE: scale_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
      vld_q <= '0;
      act_q <= 1'b0;
      row_q <= '0;
    end else begin
      gap_q <= gap_d;
      vld_q <= {vld_q[4:0], accept};
      // A new word reaches the output stage just as the previous last row
      // leaves, so a load takes priority over the row count.
      if (vld_q[5]) begin
        act_q <= 1'b1;
        row_q <= '0;
      end else if (act_q) begin
        act_q <= (row_q != 2'd2);
        row_q <= row_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[5]) begin
      sing_q <= det_zero;
      for (int k = 0; k < ROWS; k++) begin
        hold_q[k] <= det_zero ? '0 : row_d[k];
      end
    end
  end

  always_comb begin
    case (row_q)
      2'd0:    out_row = hold_q[0];
      2'd1:    out_row = hold_q[1];
      default: out_row = hold_q[2];
    endcase
  end

  assign done_o      = act_q;
  assign row_index_o = row_q;
  assign col0_o      = out_row.c0;
  assign col1_o      = out_row.c1;
  assign col2_o      = out_row.c2;
  assign col3_o      = out_row.c3;
  assign last_o      = act_q && (row_q == 2'd2);
  assign singular_o  = sing_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after an accepted word");

  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !vld_q[0] && !vld_q[1])
    else $error("words accepted closer than three cycles");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> !act_q || (row_q == 2'd2))
    else $error("output stage reloaded while rows still pending");

  a_row_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && row_index_o == 2'd0) |=> (done_o && row_index_o == 2'd1))
    else $error("row 1 did not follow row 0");

endmodule

`default_nettype wire

>>> bench/camera_view_matrix_recenter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// camera_view_matrix_recenter_unit_tb
// Drives matrix and translation words through the recenter unit under several
// recenter and scale settings, predicts each of the three row words at full
// width and compares them field by field as they appear on the result ports.
// ----------------------------------------------------------------------------

module camera_view_matrix_recenter_unit_tb import cvmr_pkg::*; ();

  localparam int TIMEOUT_CYCLES = 200000;
  localparam int DRAIN_CYCLES   = 12;

  typedef struct packed {
    logic [8:0][31:0] rot;
    logic [2:0][31:0] tv;
  } view_word_t;

  typedef struct packed {
    logic [1:0]  row_idx;
    logic [31:0] c0;
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] c3;
    logic        last;
    logic        sing;
  } row_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_RECENTER_X;
  word_t       cfg_data_i = '0;
  word_t       rot_i [9];
  word_t       view_t_i [3];
  logic        done_o;
  logic [1:0]  row_index_o;
  word_t       col0_o, col1_o, col2_o, col3_o;
  logic        last_o, singular_o;

  view_word_t  pending_words[$];
  row_word_t   expected_rows[$];
  word_t       recenter_m [3];
  word_t       scale_m;
  int          gap_mode;   // 0: no gaps, 1: random gaps
  int          gap_left;
  int          errors;
  int          words_sent;
  int          rows_seen;
  int          singular_seen;
  int          cycle_count;

  initial begin
    for (int i = 0; i < 9; i++) rot_i[i] = '0;
    for (int i = 0; i < 3; i++) view_t_i[i] = '0;
  end

  always #10 clk_i = ~clk_i;

  camera_view_matrix_recenter_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .rot_00_i(rot_i[0]), .rot_01_i(rot_i[1]), .rot_02_i(rot_i[2]),
    .rot_10_i(rot_i[3]), .rot_11_i(rot_i[4]), .rot_12_i(rot_i[5]),
    .rot_20_i(rot_i[6]), .rot_21_i(rot_i[7]), .rot_22_i(rot_i[8]),
    .view_tx_i(view_t_i[0]), .view_ty_i(view_t_i[1]), .view_tz_i(view_t_i[2]),
    .done_o(done_o), .row_index_o(row_index_o),
    .col0_o(col0_o), .col1_o(col1_o), .col2_o(col2_o), .col3_o(col3_o),
    .last_o(last_o), .singular_o(singular_o)
  );

  // Exact inverse-view rows; the translation column reduces to
  // scale * (t_k - sum_i R[i][k] * rc_i), truncated toward zero and saturated.
  task automatic push_view_rows(input view_word_t w);
    logic signed [127:0] r [9];
    logic signed [127:0] det, acc, q;
    logic                sing;
    row_word_t           row;
    for (int i = 0; i < 9; i++) r[i] = signed'(w.rot[i]);
    det = r[0]*r[4]*r[8] - r[0]*r[5]*r[7] + r[1]*r[5]*r[6]
        - r[1]*r[3]*r[8] + r[2]*r[3]*r[7] - r[2]*r[4]*r[6];
    sing = (det == 0);
    for (int k = 0; k < 3; k++) begin
      row = '0;
      row.row_idx = k[1:0];
      row.last = (k == 2);
      row.sing = sing;
      if (!sing) begin
        row.c0 = w.rot[k];
        row.c1 = w.rot[3 + k];
        row.c2 = w.rot[6 + k];
        acc = 128'(signed'(w.tv[k])) * 128'sd65536;
        for (int i = 0; i < 3; i++)
          acc = acc - r[3*i + k] * 128'(recenter_m[i]);
        acc = acc * 128'(scale_m);
        if (acc < 0) q = -((-acc) >>> (2 * FRAC_BITS));
        else q = acc >>> (2 * FRAC_BITS);
        if (q > 128'sd2147483647) row.c3 = 32'h7fff_ffff;
        else if (q < -128'sd2147483648) row.c3 = 32'h8000_0000;
        else row.c3 = q[31:0];
      end
      expected_rows.push_back(row);
    end
  endtask

  // Driver: launches pending words, with random idle gaps when gap_mode is set.
  always @(posedge clk_i) begin
    logic       start_n;
    view_word_t w;
    start_n = start;
    if (rst_ni) begin
      if (start && !busy) begin
        start_n = 1'b0;
        if (gap_mode != 0) begin
          case ($urandom_range(9))
            0: gap_left = $urandom_range(40, 10);
            1, 2, 3: gap_left = $urandom_range(3, 1);
            default: gap_left = 0;
          endcase
        end
      end
      if (!start_n) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          for (int i = 0; i < 9; i++) rot_i[i] <= w.rot[i];
          for (int i = 0; i < 3; i++) view_t_i[i] <= w.tv[i];
          start_n = 1'b1;
        end
      end
    end
    start <= start_n;
  end

  // Predict at the accepting edge, with the configuration in force then.
  always @(posedge clk_i) begin
    view_word_t w;
    if (rst_ni && start && !busy) begin
      for (int i = 0; i < 9; i++) w.rot[i] = rot_i[i];
      for (int i = 0; i < 3; i++) w.tv[i] = view_t_i[i];
      push_view_rows(w);
      words_sent++;
    end
  end

  // Monitor: every strobed row word must match the oldest prediction.
  always @(posedge clk_i) begin
    row_word_t e;
    if (rst_ni && done_o) begin
      rows_seen++;
      if (expected_rows.size() == 0) begin
        $error("row word with no prediction pending: row %0d", row_index_o);
        errors++;
      end else begin
        e = expected_rows.pop_front();
        if (e.sing && e.last) singular_seen++;
        if (row_index_o !== e.row_idx) begin
          $error("row_index expected %0d got %0d", e.row_idx, row_index_o); errors++;
        end
        if (col0_o !== e.c0) begin
          $error("col0 expected %h got %h", e.c0, col0_o); errors++;
        end
        if (col1_o !== e.c1) begin
          $error("col1 expected %h got %h", e.c1, col1_o); errors++;
        end
        if (col2_o !== e.c2) begin
          $error("col2 expected %h got %h", e.c2, col2_o); errors++;
        end
        if (col3_o !== e.c3) begin
          $error("col3 expected %h got %h", e.c3, col3_o); errors++;
        end
        if (last_o !== e.last) begin
          $error("last expected %b got %b", e.last, last_o); errors++;
        end
        if (singular_o !== e.sing) begin
          $error("singular expected %b got %b", e.sing, singular_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("timeout with %0d row words outstanding", expected_rows.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_words.size() > 0 || start || expected_rows.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input word_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_SCENE_SCALE) scale_m = data;
    else recenter_m[idx] = data;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(input word_t rx, ry, rz, sc);
    write_reg(REG_RECENTER_X, rx);
    write_reg(REG_RECENTER_Y, ry);
    write_reg(REG_RECENTER_Z, rz);
    write_reg(REG_SCENE_SCALE, sc);
    @(posedge clk_i);
  endtask

  function automatic word_t rand_field();
    case ($urandom_range(7))
      0: return $urandom();
      1: return 32'h0;
      2: return ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
      3: return ($urandom_range(1)) ? 32'h0001_0000 : 32'hffff_0000;
      default: return word_t'($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic view_word_t rand_view_word();
    view_word_t w;
    int         src, dst;
    bit         by_row;
    for (int i = 0; i < 9; i++) w.rot[i] = rand_field();
    for (int i = 0; i < 3; i++) w.tv[i] = rand_field();
    // Now and then force a repeated row or column so the matrix is singular.
    if ($urandom_range(7) == 0) begin
      src = $urandom_range(2);
      dst = (src + 1 + $urandom_range(1)) % 3;
      by_row = ($urandom_range(1) != 0);
      for (int j = 0; j < 3; j++) begin
        if (by_row) w.rot[3*dst + j] = w.rot[3*src + j];
        else w.rot[3*j + dst] = w.rot[3*j + src];
      end
    end
    return w;
  endfunction

  function automatic view_word_t make_word(input word_t a, b, c, d, e, f, g, h, k,
                                           input word_t x, y, z);
    view_word_t w;
    w.rot = {k, h, g, f, e, d, c, b, a};
    w.tv  = {z, y, x};
    return w;
  endfunction

  task automatic queue_random(input int count);
    repeat (count) pending_words.push_back(rand_view_word());
    wait_idle();
  endtask

  localparam word_t ONE  = 32'sh0001_0000;
  localparam word_t MONE = -32'sh0001_0000;
  localparam word_t MAXW = 32'sh7fff_ffff;
  localparam word_t MINW = 32'sh8000_0000;

  initial begin
    errors = 0; words_sent = 0; rows_seen = 0; singular_seen = 0;
    cycle_count = 0; gap_left = 0; gap_mode = 0;
    recenter_m[0] = '0; recenter_m[1] = '0; recenter_m[2] = '0;
    scale_m = ONE;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under reset configuration, back to back.
    pending_words.push_back(make_word(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, ONE, MONE, 32'sh0003_8000));
    pending_words.push_back(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0, ONE, ONE, ONE));
    pending_words.push_back(make_word(ONE, ONE, 0, ONE, ONE, 0, 0, 0, ONE, 5, 6, 7));
    pending_words.push_back(make_word(MAXW, 0, 0, 0, MAXW, 0, 0, 0, MAXW, MAXW, MINW, 0));
    pending_words.push_back(make_word(MINW, 0, 0, 0, MINW, 0, 0, 0, MINW, MINW, MAXW, MONE));
    pending_words.push_back(make_word(0, ONE, 0, 0, 0, ONE, ONE, 0, 0, MAXW, MAXW, MAXW));
    pending_words.push_back(make_word(MAXW, MINW, MAXW, MINW, MAXW, MINW, MAXW, MINW, 1,
                                      MINW, MINW, MINW));
    pending_words.push_back(make_word(1, 0, 0, 0, 1, 0, 0, 0, 1, 32'hffff_ffff, 1, 0));
    pending_words.push_back(make_word(MONE, 0, 0, 0, MONE, 0, 0, 0, MONE, 3, -3, 0));
    wait_idle();

    // Large recenter and scale drive col3 into both saturation limits.
    set_config(MAXW, MINW, MAXW, MAXW);
    pending_words.push_back(make_word(MAXW, 0, 0, 0, MAXW, 0, 0, 0, MAXW, 0, 0, 0));
    pending_words.push_back(make_word(MINW, 0, 0, 0, MAXW, 0, 0, 0, MINW, MAXW, MINW, 1));
    pending_words.push_back(make_word(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0));
    wait_idle();
    set_config(MINW, MINW, MINW, MINW);
    pending_words.push_back(make_word(MAXW, 0, 0, 0, MINW, 0, 0, 0, MAXW, MINW, MAXW, 0));
    pending_words.push_back(make_word(ONE, ONE, ONE, 0, ONE, ONE, 0, 0, ONE, 1, 2, 3));
    wait_idle();
    set_config(0, 0, 0, 0);
    pending_words.push_back(make_word(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, MAXW, MINW, ONE));
    wait_idle();

    // Random words under several settings, with and without idle gaps.
    gap_mode = 1;
    set_config(32'sh0002_0000, -32'sh0001_8000, 32'sh0000_4000, ONE);
    queue_random(40);
    set_config($urandom(), $urandom(), $urandom(), $urandom());
    queue_random(40);
    gap_mode = 0;
    set_config(word_t'($urandom_range(32'h000f_ffff)), MONE, 0, MONE);
    queue_random(30);
    gap_mode = 1;
    set_config(MAXW, MINW, 0, 32'sh0000_0001);
    queue_random(35);
    set_config($urandom(), $urandom(), $urandom(), 32'sh0000_8000);
    queue_random(35);

    $display("Covered %0d words, %0d row words (%0d singular words), across nine settings",
             words_sent, rows_seen, singular_seen);
    $display("including saturating recenter and scale values and zero scale.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
